### hdl/nsr_pkg.sv
`timescale 1ns / 1ps

package nsr_pkg;

   localparam int INT_BITS        = 16;
   localparam int DEF_VALUE_BITS  = 32;
   localparam int DEF_FRAC_BITS   = 40;
   localparam int TOL_BITS        = 32;
   localparam int LIMIT_BITS      = 6;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [TOL_BITS-1:0]   TOL_RESET   = 32'd11;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd40;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITER_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SQUARE
   } state_type;

endpackage

### hdl/nsr_div.sv
`timescale 1ns / 1ps

module nsr_div import nsr_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [VALUE_BITS-1:0]               value,
   input  logic [INT_BITS+FRAC_BITS-1:0]       divisor,
   output logic                                done,
   output logic [INT_BITS+FRAC_BITS+1:0]       quotient
);

   localparam int R    = INT_BITS + FRAC_BITS;
   localparam int QW   = R + 2;
   localparam int NW   = VALUE_BITS + 2 * FRAC_BITS;
   localparam int CNTW = $clog2(NW + 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] shreg_ff, shreg_in;
   logic [R-1:0]      rem_ff, rem_in;
   logic [R-1:0]      d_ff, d_in;
   logic [QW-1:0]     q_ff, q_in;
   logic              ovf_ff, ovf_in;
   logic              dz_ff, dz_in;

   logic [R:0]        rem_shift;
   logic [R+1:0]      diff;
   logic              ge;

   // numerator is value followed by 2*FRAC_BITS zero bits, fed msb first
   assign rem_shift = {rem_ff, shreg_ff[VALUE_BITS-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, d_ff};
   assign ge        = !diff[R+1];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      shreg_in  = shreg_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      dz_in     = dz_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNTW'(NW);
         shreg_in  = value;
         rem_in    = '0;
         d_in      = divisor;
         q_in      = '0;
         ovf_in    = 1'b0;
         dz_in     = (divisor == '0);
      end else if (active_ff) begin
         shreg_in = {shreg_ff[VALUE_BITS-2:0], 1'b0};
         rem_in   = ge ? diff[R-1:0] : rem_shift[R-1:0];
         q_in     = {q_ff[QW-2:0], ge};
         // a bit pushed past the top means the quotient saturates
         ovf_in   = ovf_ff | q_ff[QW-1];
         cnt_in   = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      d_ff     <= d_in;
      q_ff     <= q_in;
      ovf_ff   <= ovf_in;
      dz_ff    <= dz_in;
   end

   assign done     = done_ff;
   assign quotient = dz_ff ? '0 : (ovf_ff ? '1 : q_ff);

endmodule

### hdl/nsr_sqr.sv
`timescale 1ns / 1ps

module nsr_sqr import nsr_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [INT_BITS+FRAC_BITS-1:0]         operand,
   output logic                                  done,
   output logic [2*(INT_BITS+FRAC_BITS)-1:0]     product
);

   localparam int R  = INT_BITS + FRAC_BITS;
   localparam int H  = (R + 1) / 2;
   localparam int PW = 2 * R;

   logic           active_ff, active_in;
   logic           done_ff, done_in;
   logic [1:0]     phase_ff, phase_in;
   logic [H-1:0]   lo_ff, lo_in;
   logic [H-1:0]   hi_ff, hi_in;
   logic [2*H-1:0] p_ff, p_in;
   logic [PW-1:0]  acc_ff, acc_in;

   logic [H-1:0]   mul_a, mul_b;

   // phases: lo*lo, lo*hi, hi*hi; each product is registered in p_ff and summed in the next phase
   assign mul_a = (phase_ff == 2'd2) ? hi_ff : lo_ff;
   assign mul_b = (phase_ff == 2'd0) ? lo_ff : hi_ff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      phase_in  = phase_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      p_in      = p_ff;
      acc_in    = acc_ff;
      if (start) begin
         active_in = 1'b1;
         phase_in  = 2'd0;
         lo_in     = operand[H-1:0];
         hi_in     = H'(operand >> H);
      end else if (active_ff) begin
         p_in     = (2*H)'(mul_a) * (2*H)'(mul_b);
         phase_in = phase_ff + 2'd1;
         unique case (phase_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = PW'(p_ff);
            2'd2: acc_in = acc_ff + (PW'(p_ff) << (H + 1));
            2'd3: begin
               acc_in    = acc_ff + (PW'(p_ff) << (2 * H));
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         phase_ff  <= 2'd0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### hdl/newton_square_root_core.sv
`timescale 1ns / 1ps

// channel   ports                                          transfer
// input     start, busy, req_value                         start high while busy low
// result    rsp_valid, rsp_root, rsp_iterations, rsp_capped rsp_valid high, one cycle
// config    csr_we, csr_index, csr_wdata                   csr_we high
//
// one Newton step is one run of the restoring divider, which makes one quotient bit
// per cycle, followed by one run of the squarer.
// an item takes n steps, n from 1 to iteration_limit (1 when the limit is 0).
// busy stays high from the accepting edge until the result strobe.
// reset is synchronous: tolerance 11, iteration limit 40, no item in flight.
// results are not held back; the receiver must take each strobe.

module newton_square_root_core import nsr_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [VALUE_BITS-1:0]             req_value,
   output logic                              rsp_valid,
   output logic [INT_BITS+FRAC_BITS-1:0]     rsp_root,
   output logic [LIMIT_BITS-1:0]             rsp_iterations,
   output logic                              rsp_capped,
   input  logic                              csr_we,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]          csr_wdata
);

   localparam int R  = INT_BITS + FRAC_BITS;
   localparam int QW = R + 2;
   localparam int NW = VALUE_BITS + 2 * FRAC_BITS;
   localparam int TW = TOL_BITS + FRAC_BITS;
   localparam int BW = ((NW > TW) ? NW : TW) + 1;
   localparam int PW = 2 * R;
   localparam int CW = (PW > BW) ? PW : BW;

   localparam logic [R-1:0] G_INIT   = R'(2) << FRAC_BITS;
   localparam logic [R-1:0] ROOT_MAX = '1;

   state_type state_ff, state_in;

   logic [TOL_BITS-1:0]   tol_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [R-1:0]          g_ff, g_in;
   logic [LIMIT_BITS-1:0] count_ff, count_in;
   logic [BW-1:0]         bound_ff, bound_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [R-1:0]          rsp_root_ff, rsp_root_in;
   logic [LIMIT_BITS-1:0] rsp_iter_ff, rsp_iter_in;
   logic                  rsp_capped_ff, rsp_capped_in;

   logic                  div_start, div_done;
   logic [VALUE_BITS-1:0] div_value;
   logic [R-1:0]          div_divisor;
   logic [QW-1:0]         div_quot;
   logic                  sqr_start, sqr_done;
   logic [PW-1:0]         sqr_product;

   logic [R+2:0]          half_sum;
   logic [R-1:0]          g_new;
   logic                  again;

   assign half_sum = ((R+3)'(g_ff) + (R+3)'(div_quot)) >> 1;
   assign g_new    = (half_sum > (R+3)'(ROOT_MAX)) ? ROOT_MAX : half_sum[R-1:0];
   assign again    = CW'(sqr_product) >= CW'(bound_ff);

   assign div_value   = (state_ff == ST_IDLE) ? req_value : v_ff;
   assign div_divisor = (state_ff == ST_IDLE) ? G_INIT : g_ff;

   nsr_div #(
      .VALUE_BITS(VALUE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .value   (div_value),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quot)
   );

   nsr_sqr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_sqr (
      .clock  (clock),
      .reset  (reset),
      .start  (sqr_start),
      .operand(g_new),
      .done   (sqr_done),
      .product(sqr_product)
   );

   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      g_in          = g_ff;
      count_in      = count_ff;
      bound_in      = bound_ff;
      div_start     = 1'b0;
      sqr_start     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_root_in   = rsp_root_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_capped_in = rsp_capped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               v_in      = req_value;
               // keep going while g*g >= value + tolerance * 2^-FRAC_BITS
               bound_in  = (BW'(req_value) << (2 * FRAC_BITS))
                         + (BW'(tol_ff) << FRAC_BITS);
               g_in      = G_INIT;
               count_in  = '0;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               g_in      = g_new;
               count_in  = count_ff + LIMIT_BITS'(1);
               sqr_start = 1'b1;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sqr_done) begin
               if (again && (count_ff < limit_ff)) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_root_in   = g_ff;
                  rsp_iter_in   = count_ff;
                  rsp_capped_in = again;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff          <= v_in;
      g_ff          <= g_in;
      count_ff      <= count_in;
      bound_ff      <= bound_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_iter_ff   <= rsp_iter_in;
      rsp_capped_ff <= rsp_capped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOLERANCE:  tol_ff   <= csr_wdata[TOL_BITS-1:0];
            CSR_ITER_LIMIT: limit_ff <= csr_wdata[LIMIT_BITS-1:0];
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_iterations = rsp_iter_ff;
   assign rsp_capped     = rsp_capped_ff;

endmodule

### hdl/nsr_checker.sv
`timescale 1ns / 1ps

module nsr_checker import nsr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [LIMIT_BITS-1:0] rsp_iterations
);

   // an accepted item keeps the core occupied
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after an input transfer");

   // each item needs at least one full step, so strobes never sit back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on two consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iterations != '0))
      else $error("result reports zero iterations");

   // the result strobe comes with the core free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_iterations(rsp_iterations)
);
